FILE: rtl/core/bced_pkg.sv
`timescale 1ns / 1ps

package bced_pkg;

   localparam int TIME_WIDTH = 16;
   localparam int CMP_WIDTH  = 33;
   localparam logic [TIME_WIDTH-1:0] TIME_MAX = '1;

   localparam logic [11:0] BTN1_LOW  = 12'd700;
   localparam logic [11:0] BTN1_HIGH = 12'd900;
   localparam logic [11:0] BTN2_LOW  = 12'd1600;
   localparam logic [11:0] BTN2_HIGH = 12'd2000;
   localparam logic [11:0] BOTH_LOW  = 12'd500;

   localparam logic [7:0]  TICK_MS_RESET        = 8'd30;
   localparam logic [15:0] LONG_PRESS_MS_RESET  = 16'd1500;
   localparam logic [15:0] REPEAT_MS_RESET      = 16'd400;
   localparam logic [15:0] MULTI_CLICK_MS_RESET = 16'd300;

   localparam logic [2:0] CLICK_MAX = 3'd7;

   localparam logic [1:0] BUTTON_1 = 2'd1;
   localparam logic [1:0] BUTTON_2 = 2'd2;

   typedef enum logic [7:0] {
      CSR_TICK_MS        = 8'd0,
      CSR_LONG_PRESS_MS  = 8'd1,
      CSR_REPEAT_MS      = 8'd2,
      CSR_MULTI_CLICK_MS = 8'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      STG_NORMAL = 2'd0,
      STG_PRESS  = 2'd1,
      STG_LONG   = 2'd2
   } stage_type;

   typedef enum logic [2:0] {
      EV_PRESSED   = 3'd0,
      EV_DOUBLE    = 3'd1,
      EV_TRIPLE    = 3'd2,
      EV_LONG      = 3'd3,
      EV_SHORT_REL = 3'd4,
      EV_CLICK     = 3'd5,
      EV_REPEAT    = 3'd6,
      EV_LONG_REL  = 3'd7
   } event_code_type;

   typedef struct packed {
      logic [7:0]  tick_ms;
      logic [15:0] long_press_ms;
      logic [15:0] repeat_ms;
      logic [15:0] multi_click_ms;
   } cfg_type;

   typedef struct packed {
      stage_type             stage;
      logic                  raw;
      logic                  filt;
      logic [2:0]            clicks;
      logic [TIME_WIDTH-1:0] elapsed;
   } btn_state_type;

   typedef struct packed {
      btn_state_type  st;
      logic [1:0]     n;
      event_code_type ev0;
      event_code_type ev1;
   } scan_result_type;

   typedef struct packed {
      logic [1:0]     button;
      event_code_type code;
   } event_type;

   typedef struct packed {
      logic [2:0]            count;
      event_type [3:0]       ev;
   } bundle_type;

   typedef struct packed {
      logic valid;
      logic full;
   } queue_status_type;

   function automatic scan_result_type bced_scan(btn_state_type st_in, logic level,
                                                 cfg_type cfg);
      scan_result_type     r;
      logic [TIME_WIDTH:0] sum;
      logic [16:0]         m1;
      r       = '0;
      r.st    = st_in;
      r.ev0   = EV_PRESSED;
      r.ev1   = EV_PRESSED;
      sum     = {1'b0, st_in.elapsed} + (TIME_WIDTH+1)'(cfg.tick_ms);
      r.st.elapsed = sum[TIME_WIDTH] ? TIME_MAX : sum[TIME_WIDTH-1:0];
      m1      = {1'b0, cfg.multi_click_ms} + 17'd1;
      if (level != st_in.raw) begin
         r.st.raw = level;
      end else if (!(st_in.filt == st_in.raw && st_in.stage == STG_NORMAL &&
                     st_in.clicks == 3'd0)) begin
         r.st.filt = st_in.raw;
         case (st_in.stage)
            STG_PRESS: begin
               if (level) begin
                  if (CMP_WIDTH'(r.st.elapsed) > CMP_WIDTH'(cfg.long_press_ms)) begin
                     r.n          = 2'd1;
                     r.ev0        = EV_LONG;
                     r.st.elapsed = '0;
                     r.st.stage   = STG_LONG;
                  end
               end else begin
                  r.n   = 2'd2;
                  r.ev0 = EV_SHORT_REL;
                  r.ev1 = EV_CLICK;
                  if (st_in.clicks == 3'd0) begin
                     r.st.clicks = 3'd1;
                  end
                  r.st.stage = STG_NORMAL;
               end
            end
            STG_LONG: begin
               if (level) begin
                  if (CMP_WIDTH'(r.st.elapsed) > CMP_WIDTH'(cfg.repeat_ms)) begin
                     r.n          = 2'd1;
                     r.ev0        = EV_REPEAT;
                     r.st.elapsed = '0;
                  end
               end else begin
                  r.n         = 2'd1;
                  r.ev0       = EV_LONG_REL;
                  r.st.clicks = 3'd0;
                  if (CMP_WIDTH'(m1) > CMP_WIDTH'(TIME_MAX)) begin
                     r.st.elapsed = TIME_MAX;
                  end else begin
                     r.st.elapsed = TIME_WIDTH'(m1);
                  end
                  r.st.stage = STG_NORMAL;
               end
            end
            default: begin
               if (level) begin
                  r.n   = 2'd1;
                  r.ev0 = EV_PRESSED;
                  if (CMP_WIDTH'(r.st.elapsed) < CMP_WIDTH'(cfg.multi_click_ms) &&
                      st_in.clicks != 3'd0) begin
                     if (st_in.clicks < CLICK_MAX) begin
                        r.st.clicks = st_in.clicks + 3'd1;
                     end
                     if (r.st.clicks == 3'd2) begin
                        r.n   = 2'd2;
                        r.ev1 = EV_DOUBLE;
                     end else if (r.st.clicks == 3'd3) begin
                        r.n   = 2'd2;
                        r.ev1 = EV_TRIPLE;
                     end
                  end
                  r.st.elapsed = '0;
                  r.st.stage   = STG_PRESS;
               end else begin
                  if (CMP_WIDTH'(r.st.elapsed) > CMP_WIDTH'(cfg.multi_click_ms) &&
                      st_in.clicks != 3'd0) begin
                     r.st.clicks  = 3'd0;
                     r.st.elapsed = '0;
                  end
               end
            end
         endcase
      end
      return r;
   endfunction

endpackage

FILE: rtl/core/bced_front.sv
`timescale 1ns / 1ps

module bced_front (
   input  logic                 clock,
   input  logic                 reset,
   input  bced_pkg::cfg_type    cfg,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [11:0]          req_adc_sample,
   input  logic                 queue_full,
   output logic                 push,
   output bced_pkg::bundle_type push_data
);
   import bced_pkg::*;

   btn_state_type   btn_ff [2];
   btn_state_type   btn_in [2];
   scan_result_type r1;
   scan_result_type r2;
   logic            level1;
   logic            level2;
   logic            accept;
   event_type       b1e0, b1e1, b2e0, b2e1;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;

   always_comb begin
      level1 = 1'b0;
      level2 = 1'b0;
      if (req_adc_sample > BTN1_LOW && req_adc_sample < BTN1_HIGH) begin
         level1 = 1'b1;
      end else if (req_adc_sample > BTN2_LOW && req_adc_sample < BTN2_HIGH) begin
         level2 = 1'b1;
      end else if (req_adc_sample > BOTH_LOW && req_adc_sample < BTN1_LOW) begin
         level1 = 1'b1;
         level2 = 1'b1;
      end
   end

   always_comb begin
      r1 = bced_scan(btn_ff[0], level1, cfg);
      r2 = bced_scan(btn_ff[1], level2, cfg);
      btn_in[0] = accept ? r1.st : btn_ff[0];
      btn_in[1] = accept ? r2.st : btn_ff[1];
   end

   always_comb begin
      b1e0 = '{button: BUTTON_1, code: r1.ev0};
      b1e1 = '{button: BUTTON_1, code: r1.ev1};
      b2e0 = '{button: BUTTON_2, code: r2.ev0};
      b2e1 = '{button: BUTTON_2, code: r2.ev1};
      push_data.count = 3'(r1.n) + 3'(r2.n);
      push_data.ev[0] = (r1.n != 2'd0) ? b1e0 : b2e0;
      push_data.ev[1] = (r1.n == 2'd2) ? b1e1 : ((r1.n == 2'd1) ? b2e0 : b2e1);
      push_data.ev[2] = (r1.n == 2'd2) ? b2e0 : b2e1;
      push_data.ev[3] = b2e1;
      push = accept && (push_data.count != 3'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         btn_ff[0] <= '{stage: STG_NORMAL, default: '0};
         btn_ff[1] <= '{stage: STG_NORMAL, default: '0};
      end else begin
         btn_ff[0] <= btn_in[0];
         btn_ff[1] <= btn_in[1];
      end
   end

endmodule

FILE: rtl/core/bced_queue.sv
`timescale 1ns / 1ps

module bced_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  bced_pkg::bundle_type       push_data,
   input  logic                       pop,
   output bced_pkg::queue_status_type status,
   output bced_pkg::bundle_type       head
);
   import bced_pkg::*;

   bundle_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign status.valid = (count_ff != 2'd0);
   assign status.full  = (count_ff == 2'd2);
   assign head         = entry_ff[rd_ptr_ff];
   assign do_push      = push && !status.full;
   assign do_pop       = pop && status.valid;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: rtl/core/bced_back.sv
`timescale 1ns / 1ps

module bced_back (
   input  logic                       clock,
   input  logic                       reset,
   input  bced_pkg::queue_status_type status,
   input  bced_pkg::bundle_type       head,
   output logic                       pop,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [1:0]                 rsp_button,
   output logic [2:0]                 rsp_event_code,
   output logic                       rsp_last
);
   import bced_pkg::*;

   logic           valid_ff, valid_in;
   logic [1:0]     idx_ff, idx_in;
   event_type      ev_ff;
   logic           last_ff;
   logic           load;
   logic           is_last;

   assign load    = status.valid && (!valid_ff || rsp_ready);
   assign is_last = (({1'b0, idx_ff} + 3'd1) == head.count);
   assign pop     = load && is_last;

   always_comb begin
      valid_in = valid_ff;
      idx_in   = idx_ff;
      if (load) begin
         valid_in = 1'b1;
         idx_in   = is_last ? 2'd0 : idx_ff + 2'd1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         ev_ff   <= head.ev[idx_ff];
         last_ff <= is_last;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_button     = ev_ff.button;
   assign rsp_event_code = ev_ff.code;
   assign rsp_last       = last_ff;

endmodule

FILE: rtl/core/button_click_event_detector_unit.sv
`timescale 1ns / 1ps

// Button click event detector. Each request transaction is one scan tick with a
// twelve bit ladder ADC sample; the front end decodes it, updates both buttons'
// debounce, timer and press state and queues the tick's events in the cycle it is accepted.
// The back end sends them one response transaction per cycle while rsp_ready
// is held high, in order, with rsp_last marking the final event of a tick;
// ticks without events send nothing. The front end takes a new tick whenever
// the queue is not full, while the back end sends each tick's events (up to
// four) through the single event output register. The first event of a tick
// passes through the queue and the event output register before it is
// presented. Register writes are taken every cycle
// and should be made only while the block is idle.
module button_click_event_detector_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [15:0] csr_wdata,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [11:0] req_adc_sample,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_button,
   output logic [2:0]  rsp_event_code,
   output logic        rsp_last
);
   import bced_pkg::*;

   cfg_type          cfg_ff, cfg_in;
   logic             push;
   bundle_type       push_data;
   bundle_type       head;
   queue_status_type status;
   logic             pop;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_TICK_MS:        cfg_in.tick_ms        = csr_wdata[7:0];
            CSR_LONG_PRESS_MS:  cfg_in.long_press_ms  = csr_wdata;
            CSR_REPEAT_MS:      cfg_in.repeat_ms      = csr_wdata;
            CSR_MULTI_CLICK_MS: cfg_in.multi_click_ms = csr_wdata;
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tick_ms        <= TICK_MS_RESET;
         cfg_ff.long_press_ms  <= LONG_PRESS_MS_RESET;
         cfg_ff.repeat_ms      <= REPEAT_MS_RESET;
         cfg_ff.multi_click_ms <= MULTI_CLICK_MS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   bced_front u_front (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_adc_sample (req_adc_sample),
      .queue_full     (status.full),
      .push           (push),
      .push_data      (push_data)
   );

   bced_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .status    (status),
      .head      (head)
   );

   bced_back u_back (
      .clock          (clock),
      .reset          (reset),
      .status         (status),
      .head           (head),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_button     (rsp_button),
      .rsp_event_code (rsp_event_code),
      .rsp_last       (rsp_last)
   );

endmodule
